[hdl/lcr_pkg.sv]
// Shared types, widths and helpers for the line clipper.
package lcr_pkg;

	localparam int CW = 16;             // coordinate width
	localparam int EW = CW + 1;         // edge sums (right, bottom)
	localparam int DW = CW + 2;         // edge minus point
	localparam int PW = 2 * CW + 2;     // products
	localparam int NW = 2 * CW + 3;     // Cramer numerators
	localparam int BW = 2 * CW + 4;     // span compare width
	localparam int MW = CW;             // divisor magnitude
	localparam int QW = CW + 1;         // quotient magnitude
	localparam int SPS = 4;             // divider bits per stage
	localparam int DIV_STAGES = (QW + SPS - 1) / SPS;
	localparam int IW = 3;              // register index width

	typedef enum logic [IW-1:0] {
		REG_X = 3'd0,
		REG_Y = 3'd1,
		REG_W = 3'd2,
		REG_H = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [CW-2:0]        w;
		logic [CW-2:0]        h;
	} region_t;

	typedef struct packed {
		logic [NW-1:0] num;
		logic [MW-1:0] den;
		logic          neg;
	} lane_t;

	typedef struct packed {
		logic signed [EW-1:0] xs;
		logic signed [EW-1:0] ys;
		logic signed [EW-1:0] xe;
		logic signed [EW-1:0] ye;
		logic                 qxs;
		logic                 qys;
		logic                 qxe;
		logic                 qye;
		logic                 ok;
	} side_t;

	typedef struct packed {
		lane_t a;
		lane_t b;
		side_t side;
	} div_t;

	typedef struct packed {
		logic [NW-1:0] ra;
		logic [NW-1:0] rb;
		logic [QW-1:0] qa;
		logic [QW-1:0] qb;
		logic [MW-1:0] da;
		logic [MW-1:0] db;
		logic          na;
		logic          nb;
		side_t         side;
	} dstage_t;

	function automatic logic signed [CW-1:0] sat(input logic signed [QW:0] v);
		logic signed [CW-1:0] r;
		if (v[QW:CW-1] != {(QW-CW+2){v[QW]}})
			r = v[QW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		else
			r = v[CW-1:0];
		return r;
	endfunction

endpackage

[hdl/lcr_front.sv]
// Front pipeline: Cramer products, numerators, span tests and divider setup.
module lcr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lcr_pkg::region_t            region,
	input  logic signed [lcr_pkg::CW-1:0] dir_x,
	input  logic signed [lcr_pkg::CW-1:0] dir_y,
	input  logic signed [lcr_pkg::CW-1:0] point_x,
	input  logic signed [lcr_pkg::CW-1:0] point_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lcr_pkg::div_t               out_data
);
	import lcr_pkg::*;

	function automatic lane_t mk_lane(input logic signed [NW-1:0] n,
	                                  input logic signed [CW-1:0] d);
		lane_t l;
		l.num = n[NW-1] ? NW'(-n) : NW'(n);
		l.den = d[CW-1] ? MW'(-d) : MW'(d);
		l.neg = n[NW-1] ^ d[CW-1];
		return l;
	endfunction

	logic signed [EW-1:0] left, right, top, bottom;
	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	// stage 1
	logic signed [DW-1:0] tmy, bmy, lmx, rmx;
	logic signed [CW-1:0] dx_s1, dy_s1, px_s1, py_s1;
	logic signed [PW-1:0] dypx_s1, dxt_s1, dxb_s1, dyl_s1, dyr_s1, dxpy_s1;
	logic [MW-1:0]        adx_s1, ady_s1;

	// stage 2
	logic signed [CW-1:0] dx_s2, dy_s2, px_s2, py_s2;
	logic signed [NW-1:0] nt_s2, nb_s2, nl_s2, nr_s2;
	logic signed [BW-1:0] bl_s2, br_s2, bt_s2, bb_s2;

	// stage 3
	logic signed [BW-1:0] nts, nbs, nls, nrs;
	logic st_top, st_left, en_bot, en_right;
	div_t d3;
	div_t d_s3;

	assign left   = EW'(region.x);
	assign top    = EW'(region.y);
	assign right  = EW'(region.x) + $signed({2'b00, region.w});
	assign bottom = EW'(region.y) + $signed({2'b00, region.h});

	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	assign tmy = DW'(top) - DW'(point_y);
	assign bmy = DW'(bottom) - DW'(point_y);
	assign lmx = DW'(left) - DW'(point_x);
	assign rmx = DW'(right) - DW'(point_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1   <= dir_x;
			dy_s1   <= dir_y;
			px_s1   <= point_x;
			py_s1   <= point_y;
			dypx_s1 <= PW'(dir_y) * PW'(point_x);
			dxt_s1  <= PW'(dir_x) * PW'(tmy);
			dxb_s1  <= PW'(dir_x) * PW'(bmy);
			dyl_s1  <= PW'(dir_y) * PW'(lmx);
			dyr_s1  <= PW'(dir_y) * PW'(rmx);
			dxpy_s1 <= PW'(dir_x) * PW'(point_y);
			adx_s1  <= dir_x[CW-1] ? MW'(-dir_x) : MW'(dir_x);
			ady_s1  <= dir_y[CW-1] ? MW'(-dir_y) : MW'(dir_y);
		end
		if (en2) begin
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			nt_s2 <= NW'(dypx_s1) + NW'(dxt_s1);
			nb_s2 <= NW'(dypx_s1) + NW'(dxb_s1);
			nl_s2 <= NW'(dyl_s1) + NW'(dxpy_s1);
			nr_s2 <= NW'(dyr_s1) + NW'(dxpy_s1);
			bl_s2 <= BW'(left)   * BW'($signed({1'b0, ady_s1}));
			br_s2 <= BW'(right)  * BW'($signed({1'b0, ady_s1}));
			bt_s2 <= BW'(top)    * BW'($signed({1'b0, adx_s1}));
			bb_s2 <= BW'(bottom) * BW'($signed({1'b0, adx_s1}));
		end
		if (en3) d_s3 <= d3;
	end

	// fold the divisor sign into the numerator so the bounds need no flip
	assign nts = dy_s2[CW-1] ? -BW'(nt_s2) : BW'(nt_s2);
	assign nbs = dy_s2[CW-1] ? -BW'(nb_s2) : BW'(nb_s2);
	assign nls = dx_s2[CW-1] ? -BW'(nl_s2) : BW'(nl_s2);
	assign nrs = dx_s2[CW-1] ? -BW'(nr_s2) : BW'(nr_s2);

	assign st_top   = (nts >= bl_s2) && (nts <= br_s2);
	assign st_left  = (nls >= bt_s2) && (nls <= bb_s2);
	assign en_bot   = (nbs >= bl_s2) && (nbs <= br_s2);
	assign en_right = (nrs >= bt_s2) && (nrs <= bb_s2);

	always_comb begin
		d3 = '0;
		d3.a.den = MW'(1);
		d3.b.den = MW'(1);
		d3.side.ok = 1'b1;
		if (dy_s2 == '0) begin
			if (dx_s2 != '0) begin
				d3.side.xs = left;
				d3.side.ys = EW'(py_s2);
				d3.side.xe = right;
				d3.side.ye = EW'(py_s2);
			end
		end else if (dx_s2 == '0) begin
			d3.side.xs = EW'(px_s2);
			d3.side.ys = top;
			d3.side.xe = EW'(px_s2);
			d3.side.ye = bottom;
		end else if ((st_top || st_left) && (en_bot || en_right)) begin
			if (st_top) begin
				d3.a        = mk_lane(nt_s2, dy_s2);
				d3.side.qxs = 1'b1;
				d3.side.ys  = top;
			end else begin
				d3.a        = mk_lane(nl_s2, dx_s2);
				d3.side.xs  = left;
				d3.side.qys = 1'b1;
			end
			if (en_bot) begin
				d3.b        = mk_lane(nb_s2, dy_s2);
				d3.side.qxe = 1'b1;
				d3.side.ye  = bottom;
			end else begin
				d3.b        = mk_lane(nr_s2, dx_s2);
				d3.side.xe  = right;
				d3.side.qye = 1'b1;
			end
		end else begin
			d3.side.ok = 1'b0;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

[hdl/lcr_div_pipe.sv]
// Pipelined two-lane restoring divider, SPS quotient bits per stage.
module lcr_div_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lcr_pkg::div_t     in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output lcr_pkg::dstage_t  out_data
);
	import lcr_pkg::*;

	dstage_t seed;
	dstage_t src [DIV_STAGES];
	dstage_t nxt [DIV_STAGES];
	dstage_t st_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] v_s;
	logic [DIV_STAGES-1:0] vin;
	logic [DIV_STAGES-1:0] en;

	always_comb begin
		seed      = '0;
		seed.ra   = in_data.a.num;
		seed.rb   = in_data.b.num;
		seed.da   = in_data.a.den;
		seed.db   = in_data.b.den;
		seed.na   = in_data.a.neg;
		seed.nb   = in_data.b.neg;
		seed.side = in_data.side;
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign src[g] = seed;
			assign vin[g] = in_valid;
		end else begin : g_next
			assign src[g] = st_s[g-1];
			assign vin[g] = v_s[g-1];
		end

		if (g == DIV_STAGES - 1) begin : g_last
			assign en[g] = !v_s[g] || !out_stall;
		end else begin : g_mid
			assign en[g] = !v_s[g] || en[g+1];
		end

		always_comb begin
			int b;
			dstage_t t;
			t = src[g];
			for (int k = 0; k < SPS; k++) begin
				b = QW - 1 - (g * SPS + k);
				if (b >= 0) begin
					if (t.ra >= (NW'(t.da) << b)) begin
						t.ra = t.ra - (NW'(t.da) << b);
						t.qa = {t.qa[QW-2:0], 1'b1};
					end else begin
						t.qa = {t.qa[QW-2:0], 1'b0};
					end
					if (t.rb >= (NW'(t.db) << b)) begin
						t.rb = t.rb - (NW'(t.db) << b);
						t.qb = {t.qb[QW-2:0], 1'b1};
					end else begin
						t.qb = {t.qb[QW-2:0], 1'b0};
					end
				end
			end
			nxt[g] = t;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en[g]) begin
				v_s[g] <= vin[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) st_s[g] <= nxt[g];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_s[DIV_STAGES-1];
	assign out_data  = st_s[DIV_STAGES-1];

endmodule

[hdl/line_clip_to_rectangle.sv]
// Top level: region registers, front pipeline, divider and output register.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   dir_x dir_y point_x point_y
//  out      source     out_valid / out_stall start_x start_y end_x end_y crosses
//  cfg      sink       cfg_valid / cfg_ready cfg_index cfg_data
//
// One line per cycle while out_stall is low. A line passes through 3 front stages (products,
// numerators, span tests), 5 divider stages (4 quotient bits in each of the first four, 1 in
// the last), and the output register.
// Reset clears the valid bits and sets all region registers to 0.
// Each stage advances when it is empty or the next one takes its beat, so bubbles
// close up and a stall at the output backs up one stage at a time.
module line_clip_to_rectangle (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [lcr_pkg::CW-1:0] dir_x,
	input  logic signed [lcr_pkg::CW-1:0] dir_y,
	input  logic signed [lcr_pkg::CW-1:0] point_x,
	input  logic signed [lcr_pkg::CW-1:0] point_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [lcr_pkg::CW-1:0] start_x,
	output logic signed [lcr_pkg::CW-1:0] start_y,
	output logic signed [lcr_pkg::CW-1:0] end_x,
	output logic signed [lcr_pkg::CW-1:0] end_y,
	output logic                          crosses,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lcr_pkg::IW-1:0]        cfg_index,
	input  logic [lcr_pkg::CW-1:0]        cfg_data
);
	import lcr_pkg::*;

	region_t region_q;
	logic    f_valid, f_stall, d_valid, d_stall, en_out;
	div_t    f_data;
	dstage_t d_data;
	logic signed [QW:0] qa, qb, sx, sy, ex, ey;
	logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q;
	logic ok_q, ov_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_X:   region_q.x <= cfg_data;
				REG_Y:   region_q.y <= cfg_data;
				REG_W:   region_q.w <= cfg_data[CW-2:0];
				REG_H:   region_q.h <= cfg_data[CW-2:0];
				default: ;
			endcase
		end
	end

	lcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.region   (region_q),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.point_x  (point_x),
		.point_y  (point_y),
		.out_valid(f_valid),
		.out_stall(f_stall),
		.out_data (f_data)
	);

	lcr_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_stall (f_stall),
		.in_data  (f_data),
		.out_valid(d_valid),
		.out_stall(d_stall),
		.out_data (d_data)
	);

	assign en_out  = !ov_q || !out_stall;
	assign d_stall = !en_out;

	// apply quotient signs, then pick quotient or fixed edge per coordinate
	assign qa = d_data.na ? -$signed({1'b0, d_data.qa}) : $signed({1'b0, d_data.qa});
	assign qb = d_data.nb ? -$signed({1'b0, d_data.qb}) : $signed({1'b0, d_data.qb});
	assign sx = d_data.side.qxs ? qa : (QW+1)'(d_data.side.xs);
	assign sy = d_data.side.qys ? qa : (QW+1)'(d_data.side.ys);
	assign ex = d_data.side.qxe ? qb : (QW+1)'(d_data.side.xe);
	assign ey = d_data.side.qye ? qb : (QW+1)'(d_data.side.ye);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en_out) begin
			ov_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sx_q <= sat(sx);
			sy_q <= sat(sy);
			ex_q <= sat(ex);
			ey_q <= sat(ey);
			ok_q <= d_data.side.ok;
		end
	end

	assign out_valid = ov_q;
	assign start_x   = sx_q;
	assign start_y   = sy_q;
	assign end_x     = ex_q;
	assign end_y     = ey_q;
	assign crosses   = ok_q;

	a_nocross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !crosses |->
			(start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0))
		else $error("no-crossing result carries nonzero endpoints");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side can advance");

	a_cfg_width: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_W |=> region_q.w == $past(cfg_data[CW-2:0]))
		else $error("width register write lost");

endmodule

[dv/line_clip_to_rectangle_tb.sv]
// Testbench for the line clipper: directed lines without stalls, and random lines with and without random stalls.
`timescale 1ns / 100ps

module line_clip_to_rectangle_tb;
	import lcr_pkg::*;

	localparam logic [IW-1:0] REG_UNUSED_LO = 3'd4;
	localparam logic [IW-1:0] REG_UNUSED_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint CMAX = 32767;
	localparam longint CMIN = -32768;

	typedef struct {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic                 cr;
	} clip_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] dir_x = '0, dir_y = '0, point_x = '0, point_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] start_x, start_y, end_x, end_y;
	logic crosses;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	// region copy kept by the predictor
	longint reg_x = 0, reg_y = 0, reg_w = 0, reg_h = 0;
	clip_t clip_q[$];
	int errors = 0;
	bit idle_en = 1'b0;
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	line_clip_to_rectangle dut (.*);

	always #5 clk = ~clk;

	function automatic logic signed [CW-1:0] clamp(input longint v);
		if (v > CMAX) return CMAX[CW-1:0];
		if (v < CMIN) return CMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic bit spans(input longint num, input longint den,
			input longint lo, input longint hi);
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		return num >= lo * den && num <= hi * den;
	endfunction

	function automatic clip_t clip_line(input longint dx, input longint dy,
			input longint px, input longint py);
		longint lft, rgt, top, bot, nt, nb, nl, nr;
		longint sx, sy, ex, ey;
		bit ok;
		clip_t r;
		lft = reg_x; rgt = reg_x + reg_w;
		top = reg_y; bot = reg_y + reg_h;
		sx = 0; sy = 0; ex = 0; ey = 0; ok = 1'b1;
		if (dy == 0) begin
			if (dx != 0) begin
				sx = lft; sy = py; ex = rgt; ey = py;
			end
		end else if (dx == 0) begin
			sx = px; sy = top; ex = px; ey = bot;
		end else begin
			nt = dy * px + dx * (top - py);
			nb = dy * px + dx * (bot - py);
			nl = dy * (lft - px) + dx * py;
			nr = dy * (rgt - px) + dx * py;
			if (spans(nt, dy, lft, rgt)) begin
				sx = nt / dy; sy = top;
			end else if (spans(nl, dx, top, bot)) begin
				sx = lft; sy = nl / dx;
			end else ok = 1'b0;
			if (ok) begin
				if (spans(nb, dy, lft, rgt)) begin
					ex = nb / dy; ey = bot;
				end else if (spans(nr, dx, top, bot)) begin
					ex = rgt; ey = nr / dx;
				end else ok = 1'b0;
			end
			if (!ok) begin
				sx = 0; sy = 0; ex = 0; ey = 0;
			end
		end
		r.sx = clamp(sx); r.sy = clamp(sy); r.ex = clamp(ex); r.ey = clamp(ey);
		r.cr = ok;
		return r;
	endfunction

	// predict on every accepted input beat, track region writes
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			clip_q.push_back(clip_line(dir_x, dir_y, point_x, point_y));
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X: reg_x = longint'(signed'(cfg_data));
				REG_Y: reg_y = longint'(signed'(cfg_data));
				REG_W: reg_w = longint'(cfg_data[CW-2:0]);
				REG_H: reg_h = longint'(cfg_data[CW-2:0]);
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		clip_t e;
		if (out_valid && !out_stall) begin
			if (clip_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = clip_q.pop_front();
				if (start_x !== e.sx) begin
					$error("start_x expected %0d got %0d", e.sx, start_x); errors++;
				end
				if (start_y !== e.sy) begin
					$error("start_y expected %0d got %0d", e.sy, start_y); errors++;
				end
				if (end_x !== e.ex) begin
					$error("end_x expected %0d got %0d", e.ex, end_x); errors++;
				end
				if (end_y !== e.ey) begin
					$error("end_y expected %0d got %0d", e.ey, end_y); errors++;
				end
				if (crosses !== e.cr) begin
					$error("crosses expected %0d got %0d", e.cr, crosses); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				burst = 300;
			end
			if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 14) - 1;
				out_stall = 1'b1;
			end else out_stall = 1'b0;
		end
	end

	task automatic send_line(input logic signed [CW-1:0] dx, input logic signed [CW-1:0] dy,
			input logic signed [CW-1:0] px, input logic signed [CW-1:0] py);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		dir_x = dx; dir_y = dy; point_x = px; point_y = py;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, then wait out the pipeline
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		wait (clip_q.size() == 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
		@(negedge clk);
		cfg_index = idx; cfg_data = data; cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_region(input longint x, input longint y, input longint w, input longint h);
		write_reg(REG_X, x[CW-1:0]);
		write_reg(REG_Y, y[CW-1:0]);
		write_reg(REG_W, {1'($urandom_range(0, 1)), w[CW-2:0]});
		write_reg(REG_H, {1'($urandom_range(0, 1)), h[CW-2:0]});
	endtask

	// mostly lines through a point in the region, the rest through a random point
	task automatic send_random_line();
		longint px, py;
		logic signed [CW-1:0] dx, dy;
		dx = 16'($urandom); dy = 16'($urandom);
		case ($urandom_range(0, 9))
			0: dx = '0;
			1: dy = '0;
			2: begin
				dx = 16'(int'($urandom_range(0, 64)) - 32);
				dy = 16'(int'($urandom_range(0, 64)) - 32);
			end
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			px = $signed(16'($urandom)); py = $signed(16'($urandom));
		end else begin
			px = reg_x + longint'($urandom_range(0, 32'(reg_w)));
			py = reg_y + longint'($urandom_range(0, 32'(reg_h)));
		end
		send_line(dx, dy, clamp(px), clamp(py));
	endtask

	task automatic test_directed();
		set_region(-160, -80, 320, 160);
		send_line(16, 0, 5, 7);
		send_line(0, -16, 5, 7);
		send_line(0, 0, 100, 100);
		send_line(16, 16, 0, 0);
		send_line(16, 8, 0, 0);
		send_line(-16, 64, 0, 0);
		send_line(16, 16, 2000, -2000);
		send_line(-32768, 32767, 0, 0);
		send_line(32767, -32768, 32767, -32768);
		send_line(-32768, -32768, -32768, 32767);
		send_line(1, -1, 3, 3);
		send_line(-1, 0, 32767, -32768);
		send_line(0, 1, -32768, 32767);
		wait_drained();
		// far corner: edge sums leave the coordinate range
		set_region(32767, 32767, 32767, 32767);
		send_line(16, 0, 0, 0);
		send_line(0, 16, 0, 0);
		send_line(1, 1, 32767, 32767);
		send_line(-3, 7, 32767, 32767);
		wait_drained();
		set_region(-32768, -32768, 0, 0);
		send_line(5, 0, 1, 2);
		send_line(16, 16, -32768, -32768);
		send_line(7, -3, -32768, -32768);
		wait_drained();
	endtask

	task automatic test_random_regions();
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: set_region(-32768, 32767, 32767, 0);
				1: set_region(0, 0, 0, 0);
				default: set_region($signed(16'($urandom)), $signed(16'($urandom)),
					$urandom_range(0, 32767), $urandom_range(0, 32767));
			endcase
			if (k > 2) set_region(-($urandom_range(0, 2000)), -($urandom_range(0, 2000)),
				$urandom_range(0, 4000), $urandom_range(0, 4000));
			repeat (230) send_random_line();
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (60) send_random_line();
		wait_drained();
	endtask

	task automatic test_unused_index();
		write_reg(REG_UNUSED_LO, 16'hFFFF);
		write_reg(REG_UNUSED_HI, 16'h8000);
		repeat (30) send_random_line();
		wait_drained();
	endtask

	task automatic test_full_rate();
		idle_en = 1'b0;
		set_region(-640, -480, 1280, 960);
		repeat (410) send_random_line();
		wait_drained();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		idle_en = 1'b1;
		test_random_regions();
		test_backpressure();
		test_unused_index();
		test_full_rate();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
